// File: rtl/wcat_pkg.sv
// Package with the constants, types and control structures of the weighted cache aging table.
`default_nettype none
package wcat_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PHY_W = CNT_W + 1;

  localparam logic [15:0] NEW_WEIGHT = 16'd10;
  localparam logic [15:0] HIT_BONUS = 16'd2;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_TRIM   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] weight;
    logic [15:0] handle;
  } entry_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ADD,
    WR_BUMP,
    WR_SORT,
    WR_CARRY,
    WR_HALF
  } wr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_CLEAR,
    CNT_TRIM
  } cnt_op_t;

  typedef struct packed {
    logic    load_req;
    logic    rd;
    logic    idx_clr;
    logic    idx_inc;
    logic    carry_load;
    logic    prev_load;
    wr_sel_t wr_sel;
    logic    swap_clr;
    cnt_op_t cnt_op;
    logic    res_hit;
    logic    res_rej;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t command;
    logic count_zero;
    logic full;
    logic max_zero;
    logic match;
    logic idx_last;
    logic idx_end;
    logic swapped;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LK_RD,
    ST_LK_CMP,
    ST_SP_START,
    ST_SP_LOAD,
    ST_SP_RD,
    ST_SP_CMP,
    ST_SP_LAST,
    ST_TRIM,
    ST_HV_RD,
    ST_HV_WR,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// File: rtl/wcat_if.sv
// Request and response channel interfaces of the weighted cache aging table.
`default_nettype none
interface wcat_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] key;
  logic [15:0] new_handle;
  logic [6:0]  max_items;

  modport source(output valid, command, key, new_handle, max_items, input ready);
  modport sink(input valid, command, key, new_handle, max_items, output ready);
endinterface

interface wcat_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [15:0] found_handle;
  logic        rejected;
  logic [6:0]  entry_total;

  modport source(output valid, hit, found_handle, rejected, entry_total, input ready);
  modport sink(input valid, hit, found_handle, rejected, entry_total, output ready);
endinterface
`default_nettype wire

// File: rtl/wcat_datapath.sv
// Datapath of the weighted cache aging table: entry memory, pointers, sort carry and results.
`default_nettype none
module wcat_datapath
  import wcat_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  output dp_stat_t         stat,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] key,
  input  wire logic [15:0] new_handle,
  input  wire logic [6:0]  max_items,
  output logic             hit,
  output logic [15:0]      found_handle,
  output logic             rejected,
  output logic [6:0]       entry_total
);

  entry_t mem [CAPACITY];
  entry_t rdata;
  entry_t carry;
  entry_t wr_data;
  logic [IDX_W-1:0] head, head_next, addr_q, prev, phys, wr_addr;
  logic [CNT_W-1:0] count, idx;
  logic [PHY_W-1:0] psum;
  logic [1:0]  req_command;
  logic [31:0] req_key;
  logic [15:0] req_handle;
  logic [6:0]  req_max;
  logic        res_hit, res_rej, swapped, wr_en, carry_less;
  logic [15:0] res_handle;
  logic [16:0] bumped;

  assign psum = PHY_W'(head) + PHY_W'(idx);
  assign phys = (psum >= PHY_W'(CAPACITY)) ? IDX_W'(psum - PHY_W'(CAPACITY)) : IDX_W'(psum);
  assign head_next = (head == '0) ? IDX_W'(CAPACITY - 1) : head - 1'b1;
  assign carry_less = carry.weight < rdata.weight;
  assign bumped = {1'b0, rdata.weight} + {1'b0, HIT_BONUS};

  always_comb begin
    wr_en = 1'b0;
    wr_addr = addr_q;
    wr_data = rdata;
    case (cmd.wr_sel)
      WR_ADD: begin
        wr_en = 1'b1;
        wr_addr = head_next;
        wr_data = '{key: req_key, weight: NEW_WEIGHT, handle: req_handle};
      end
      WR_BUMP: begin
        wr_en = 1'b1;
        wr_data.weight = bumped[16] ? 16'hFFFF : bumped[15:0];
      end
      WR_SORT: begin
        wr_en = 1'b1;
        wr_addr = prev;
        wr_data = carry_less ? rdata : carry;
      end
      WR_CARRY: begin
        wr_en = 1'b1;
        wr_addr = prev;
        wr_data = carry;
      end
      WR_HALF: begin
        wr_en = 1'b1;
        wr_data.weight = {1'b0, rdata.weight[15:1]};
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rdata <= mem[phys];
      addr_q <= phys;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      count <= '0;
      idx <= '0;
      swapped <= 1'b0;
    end else begin
      if (cmd.wr_sel == WR_ADD) begin
        head <= head_next;
      end
      case (cmd.cnt_op)
        CNT_INC: count <= count + 1'b1;
        CNT_CLEAR: count <= '0;
        CNT_TRIM: begin
          if (32'(req_max) < 32'(count)) begin
            count <= CNT_W'(req_max);
          end
        end
        default: count <= count;
      endcase
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.swap_clr) begin
        swapped <= 1'b0;
      end else if (cmd.wr_sel == WR_SORT && carry_less) begin
        swapped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_command <= command;
      req_key <= key;
      req_handle <= new_handle;
      req_max <= max_items;
      res_hit <= 1'b0;
      res_handle <= '0;
      res_rej <= 1'b0;
    end
    if (cmd.res_hit) begin
      res_hit <= 1'b1;
      res_handle <= rdata.handle;
    end
    if (cmd.res_rej) begin
      res_rej <= 1'b1;
    end
    if (cmd.carry_load || (cmd.wr_sel == WR_SORT && !carry_less)) begin
      carry <= rdata;
    end
    if (cmd.prev_load) begin
      prev <= addr_q;
    end
    if (cmd.out_load) begin
      hit <= res_hit;
      found_handle <= res_handle;
      rejected <= res_rej;
      entry_total <= 7'(count);
    end
  end

  always_comb begin
    stat.command = cmd_t'(req_command);
    stat.count_zero = (count == '0);
    stat.full = (count == CNT_W'(CAPACITY));
    stat.max_zero = (req_max == '0);
    stat.match = (rdata.key == req_key);
    stat.idx_last = ((idx + 1'b1) == count);
    stat.idx_end = (idx == count);
    stat.swapped = swapped;
  end

endmodule
`default_nettype wire

// File: rtl/wcat_ctrl.sv
// Controller state machine of the weighted cache aging table.
`default_nettype none
module wcat_ctrl
  import wcat_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (stat.command)
          CMD_LOOKUP: state_next = stat.count_zero ? ST_DONE : ST_LK_RD;
          CMD_TRIM: state_next = (stat.max_zero || stat.count_zero) ? ST_DONE : ST_SP_START;
          default: state_next = ST_DONE;
        endcase
      end
      ST_LK_RD: state_next = ST_LK_CMP;
      ST_LK_CMP: begin
        if (stat.match || stat.idx_last) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_LK_RD;
        end
      end
      ST_SP_START: state_next = ST_SP_LOAD;
      ST_SP_LOAD: state_next = stat.idx_end ? ST_SP_LAST : ST_SP_CMP;
      ST_SP_RD: state_next = ST_SP_CMP;
      ST_SP_CMP: state_next = stat.idx_last ? ST_SP_LAST : ST_SP_RD;
      ST_SP_LAST: state_next = stat.swapped ? ST_SP_START : ST_TRIM;
      ST_TRIM: state_next = ST_HV_RD;
      ST_HV_RD: state_next = ST_HV_WR;
      ST_HV_WR: state_next = stat.idx_last ? ST_DONE : ST_HV_RD;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{wr_sel: WR_NONE, cnt_op: CNT_HOLD, default: 1'b0};
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load_req = in_valid;
      end
      ST_DISPATCH: begin
        cmd.idx_clr = 1'b1;
        unique case (stat.command)
          CMD_ADD: begin
            if (stat.full) begin
              cmd.res_rej = 1'b1;
            end else begin
              cmd.wr_sel = WR_ADD;
              cmd.cnt_op = CNT_INC;
            end
          end
          CMD_TRIM: if (stat.max_zero) cmd.cnt_op = CNT_CLEAR;
          default: cmd.idx_clr = 1'b1;
        endcase
      end
      ST_LK_RD: cmd.rd = 1'b1;
      ST_LK_CMP: begin
        if (stat.match) begin
          cmd.wr_sel = WR_BUMP;
          cmd.res_hit = 1'b1;
        end else if (!stat.idx_last) begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_SP_START: begin
        cmd.rd = 1'b1;
        cmd.idx_inc = 1'b1;
        cmd.swap_clr = 1'b1;
      end
      ST_SP_LOAD: begin
        cmd.carry_load = 1'b1;
        cmd.prev_load = 1'b1;
        cmd.rd = !stat.idx_end;
      end
      ST_SP_RD: cmd.rd = 1'b1;
      ST_SP_CMP: begin
        cmd.wr_sel = WR_SORT;
        cmd.prev_load = 1'b1;
        cmd.idx_inc = !stat.idx_last;
      end
      ST_SP_LAST: begin
        cmd.wr_sel = WR_CARRY;
        cmd.idx_clr = 1'b1;
      end
      ST_TRIM: begin
        cmd.cnt_op = CNT_TRIM;
        cmd.idx_clr = 1'b1;
      end
      ST_HV_RD: cmd.rd = 1'b1;
      ST_HV_WR: begin
        cmd.wr_sel = WR_HALF;
        cmd.idx_inc = !stat.idx_last;
      end
      ST_DONE: cmd.out_load = out_free;
      default: cmd.load_req = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/weighted_cache_aging_table_unit.sv
// Top level of the weighted cache aging table.
// The table holds up to CAPACITY entries (64) in one memory used as a ring, so an add
// writes at the head and a lookup scans the entries one by one from the head.
// A trim runs stable bubble passes over the single memory read port, repeating until
// a pass makes no exchange, then halves the kept weights one entry at a time; a trim
// with max_items zero empties the table instead.
// Every request gives one response, held in an output register until taken; a new
// request is accepted once the previous one has finished.
`default_nettype none
module weighted_cache_aging_table_unit
  import wcat_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  wcat_req_if.sink   req,
  wcat_rsp_if.source rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  wcat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wcat_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .command      (req.command),
    .key          (req.key),
    .new_handle   (req.new_handle),
    .max_items    (req.max_items),
    .hit          (rsp.hit),
    .found_handle (rsp.found_handle),
    .rejected     (rsp.rejected),
    .entry_total  (rsp.entry_total)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while another was in progress");

  a_hit_or_reject: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.hit && rsp.rejected))
    else $error("response flags both hit and rejected");

  a_miss_handle: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.hit |-> rsp.found_handle == 16'd0)
    else $error("handle reported without a hit");
`endif

endmodule
`default_nettype wire

// File: bench/weighted_cache_aging_table_unit_test.sv
// Testbench that drives random and directed cache commands and checks every response.
`default_nettype none
module weighted_cache_aging_table_unit_test
  import wcat_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] key;
    logic [15:0] new_handle;
    logic [6:0]  max_items;
  } request_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] found_handle;
    logic        rejected;
    logic [6:0]  entry_total;
  } response_t;

  localparam int IDLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wcat_req_if req ();
  wcat_rsp_if rsp ();

  weighted_cache_aging_table_unit u_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  request_t  pending_requests[$];
  response_t expected_responses[$];
  int        error_count = 0;
  int        idle_cycles = 0;

  logic [31:0] table_key[CAPACITY];
  logic [15:0] table_weight[CAPACITY];
  logic [15:0] table_handle[CAPACITY];
  int          table_count = 0;

  function automatic response_t apply_request(request_t r);
    response_t   res;
    logic [31:0] k;
    logic [15:0] w, h;
    int          j;
    res = '0;
    case (r.command)
      CMD_LOOKUP: begin
        for (int i = 0; i < table_count; i++) begin
          if (table_key[i] == r.key) begin
            table_weight[i] = (table_weight[i] >= 16'hFFFE) ? 16'hFFFF
                                                              : table_weight[i] + 16'd2;
            res.hit = 1'b1;
            res.found_handle = table_handle[i];
            break;
          end
        end
      end
      CMD_ADD: begin
        if (table_count >= CAPACITY) begin
          res.rejected = 1'b1;
        end else begin
          for (int i = table_count; i > 0; i--) begin
            table_key[i] = table_key[i-1];
            table_weight[i] = table_weight[i-1];
            table_handle[i] = table_handle[i-1];
          end
          table_key[0] = r.key;
          table_weight[0] = 16'd10;
          table_handle[0] = r.new_handle;
          table_count++;
        end
      end
      CMD_TRIM: begin
        if (r.max_items == 0) begin
          table_count = 0;
        end else if (table_count > 0) begin
          for (int i = 1; i < table_count; i++) begin
            k = table_key[i];
            w = table_weight[i];
            h = table_handle[i];
            j = i;
            while (j > 0 && table_weight[j-1] < w) begin
              table_key[j] = table_key[j-1];
              table_weight[j] = table_weight[j-1];
              table_handle[j] = table_handle[j-1];
              j--;
            end
            table_key[j] = k;
            table_weight[j] = w;
            table_handle[j] = h;
          end
          if (r.max_items < table_count) table_count = r.max_items;
          for (int i = 0; i < table_count; i++) table_weight[i] = table_weight[i] >> 1;
        end
      end
      default: ;
    endcase
    res.entry_total = table_count[6:0];
    return res;
  endfunction

  function automatic request_t make_request(cmd_t c, logic [31:0] k, logic [15:0] h,
                                            logic [6:0] m);
    request_t r;
    r.command = c;
    r.key = k;
    r.new_handle = h;
    r.max_items = m;
    return r;
  endfunction

  // Keys come mostly from a small pool so that lookups hit and duplicates occur.
  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) < 8) return {28'h0, 4'($urandom_range(0, 15))};
    return $urandom();
  endfunction

  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.command <= CMD_NOP;
      req.key <= '0;
      req.new_handle <= '0;
      req.max_items <= '0;
    end else if (!req.valid || req.ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req.valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        request_t r;
        r = pending_requests.pop_front();
        expected_responses.push_back(apply_request(r));
        req.valid <= 1'b1;
        req.command <= r.command;
        req.key <= r.key;
        req.new_handle <= r.new_handle;
        req.max_items <= r.max_items;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  int stall_phase = 0;

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 97;
      rsp.ready <= (stall_phase < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (rsp.valid && rsp.ready) begin
        if (expected_responses.size() == 0) begin
          $display("%0t: unexpected response hit=%0b handle=%0h rejected=%0b total=%0d",
                   $time, rsp.hit, rsp.found_handle, rsp.rejected, rsp.entry_total);
          error_count <= error_count + 1;
        end else begin
          response_t e;
          e = expected_responses.pop_front();
          if (e.hit !== rsp.hit || e.found_handle !== rsp.found_handle ||
              e.rejected !== rsp.rejected || e.entry_total !== rsp.entry_total) begin
            $display("%0t: mismatch expected hit=%0b handle=%0h rejected=%0b total=%0d",
                     $time, e.hit, e.found_handle, e.rejected, e.entry_total);
            $display("%0t:          actual   hit=%0b handle=%0h rejected=%0b total=%0d",
                     $time, rsp.hit, rsp.found_handle, rsp.rejected, rsp.entry_total);
            error_count <= error_count + 1;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int roll;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    pending_requests.push_back(make_request(CMD_LOOKUP, 32'h0, 16'h0, 7'd0));
    pending_requests.push_back(make_request(CMD_TRIM, 32'h0, 16'h0, 7'd5));
    pending_requests.push_back(make_request(CMD_NOP, 32'hFFFFFFFF, 16'hFFFF, 7'h7F));
    pending_requests.push_back(make_request(CMD_ADD, 32'hFFFFFFFF, 16'hFFFF, 7'h7F));
    pending_requests.push_back(make_request(CMD_ADD, 32'h0, 16'h0, 7'd0));
    pending_requests.push_back(make_request(CMD_ADD, 32'h5, 16'h1234, 7'd0));
    pending_requests.push_back(make_request(CMD_ADD, 32'h5, 16'h5678, 7'd0));
    pending_requests.push_back(make_request(CMD_LOOKUP, 32'h5, 16'h0, 7'd0));
    pending_requests.push_back(make_request(CMD_LOOKUP, 32'hFFFFFFFF, 16'h0, 7'd0));
    pending_requests.push_back(make_request(CMD_LOOKUP, 32'h77, 16'h0, 7'd0));
    pending_requests.push_back(make_request(CMD_TRIM, 32'h0, 16'h0, 7'd64));
    pending_requests.push_back(make_request(CMD_TRIM, 32'h0, 16'h0, 7'd2));
    pending_requests.push_back(make_request(CMD_TRIM, 32'h0, 16'h0, 7'd0));
    for (int i = 0; i < 65; i++)
      pending_requests.push_back(make_request(CMD_ADD, i, 16'(i * 3), 7'd0));
    pending_requests.push_back(make_request(CMD_TRIM, 32'h0, 16'h0, 7'h7F));
    pending_requests.push_back(make_request(CMD_TRIM, 32'h0, 16'h0, 7'd0));

    for (int n = 0; n < 1300; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45)
        pending_requests.push_back(make_request(CMD_LOOKUP, pick_key(), 16'($urandom()),
                                                7'($urandom())));
      else if (roll < 85)
        pending_requests.push_back(make_request(CMD_ADD, pick_key(), 16'($urandom()),
                                                7'($urandom())));
      else if (roll < 93)
        pending_requests.push_back(make_request(CMD_TRIM, pick_key(), 16'($urandom()),
                                   ($urandom_range(0, 9) == 0) ? 7'($urandom())
                                                               : 7'($urandom_range(1, 20))));
      else
        pending_requests.push_back(make_request(CMD_NOP, $urandom(), 16'($urandom()),
                                                7'($urandom())));
    end

    while (pending_requests.size() > 0 || expected_responses.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_responses.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: weighted_cache_aging_table_unit.f
rtl/wcat_pkg.sv
rtl/wcat_if.sv
rtl/wcat_datapath.sv
rtl/wcat_ctrl.sv
rtl/weighted_cache_aging_table_unit.sv
bench/weighted_cache_aging_table_unit_test.sv
